@@ design/nma_pkg.sv @@
// ----------------------------------------------------------------------------
// nma_pkg: shared types and constants for the neighbour mean aggregator
// Widths, limits and the structs that pass between the aggregator modules.
// ----------------------------------------------------------------------------
package nma_pkg;

  localparam int MAX_FEATURES = 128;
  localparam int MAX_DEGREE   = 65535;

  localparam int VAL_W   = 32;                          // Q16.16 feature value
  localparam int SUM_W   = 48;                          // Q32.16 accumulator
  localparam int TOT_W   = SUM_W + 1;                   // sum plus value, no wrap
  localparam int MAG_W   = SUM_W;                       // magnitude of that total
  localparam int DEG_W   = 16;                          // degree and tally
  localparam int CFG_W   = 8;                           // feature_count register
  localparam int FPOS_W  = 7;                           // feature_position field
  localparam int POS_W   = $clog2(MAX_FEATURES);        // accumulator index
  localparam int CNT_W   = $clog2(MAX_FEATURES + 1);    // effective count
  localparam int STEP_W  = $clog2(MAG_W);               // divider step counter
  localparam int OUT_TDATA_W = ((VAL_W + FPOS_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] FEATURE_COUNT_RST = CFG_W'(128);

  // Write port of the accumulator store
  typedef struct packed {
    logic                 en;
    logic [POS_W-1:0]     addr;
    logic [SUM_W-1:0]     data;
  } nma_mem_wr_t;

  // Request to the shared divider
  typedef struct packed {
    logic                 start;
    logic                 neg;
    logic [MAG_W-1:0]     mag;
    logic [DEG_W-1:0]     divisor;
  } nma_div_req_t;

  // Status back from the shared divider
  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [VAL_W-1:0]     result;
  } nma_div_rsp_t;

endpackage

@@ design/nma_sum_mem.sv @@
// ----------------------------------------------------------------------------
// nma_sum_mem: per-position accumulator store
// One write and one registered read per cycle. A valid bit per entry makes
// entries that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module nma_sum_mem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  nma_pkg::nma_mem_wr_t            wr,
  input  logic                            rd_en,
  input  logic [nma_pkg::POS_W-1:0]       rd_addr,
  output logic [nma_pkg::SUM_W-1:0]       rd_data
);
  import nma_pkg::*;

  logic [SUM_W-1:0]        mem [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] valid_r;
  logic [SUM_W-1:0]        rd_data_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

@@ design/nma_div.sv @@
// ----------------------------------------------------------------------------
// nma_div: shared restoring divider
// Divides a 48-bit magnitude by a 16-bit degree one quotient bit per cycle,
// then applies the sign and saturates to the signed 32-bit range.
// ----------------------------------------------------------------------------
module nma_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nma_pkg::nma_div_req_t  req,
  output nma_pkg::nma_div_rsp_t  rsp
);
  import nma_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DEG_W-1:0]    rem_r, rem_nxt;
  logic [MAG_W-1:0]    quo_r, quo_nxt;
  logic [DEG_W-1:0]    den_r, den_nxt;
  logic                neg_r, neg_nxt;
  logic [DEG_W:0]      shifted;
  logic                fits;
  logic                sat;
  logic [VAL_W-1:0]    result;

  assign shifted = {rem_r, quo_r[MAG_W-1]};
  assign fits    = shifted >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (busy_r) begin
      rem_nxt = fits ? DEG_W'(shifted - {1'b0, den_r}) : DEG_W'(shifted);
      quo_nxt = {quo_r[MAG_W-2:0], fits};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(MAG_W - 1);
      rem_nxt  = '0;
      quo_nxt  = req.mag;
      den_nxt  = req.divisor;
      neg_nxt  = req.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
  end

  // A negative quotient may reach exactly 2^31; anything larger saturates.
  always_comb begin
    if (neg_r) begin
      sat    = (|quo_r[MAG_W-1:VAL_W]) || (quo_r[VAL_W-1] && (|quo_r[VAL_W-2:0]));
      result = sat ? {1'b1, {(VAL_W-1){1'b0}}} : VAL_W'(-quo_r[VAL_W-1:0]);
    end else begin
      sat    = |quo_r[MAG_W-1:VAL_W-1];
      result = sat ? {1'b0, {(VAL_W-1){1'b1}}} : quo_r[VAL_W-1:0];
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.result = result;

endmodule

@@ design/neighbor_mean_aggregate.sv @@
// ----------------------------------------------------------------------------
// neighbor_mean_aggregate: mean of in-neighbour feature vectors
// Accumulates neighbour features per position and, on the final neighbour,
// divides each position's total by the degree with a shared divider.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  in_     | sink      | tdata: feature_value; tlast: final_neighbor
//  out_    | source    | tdata: mean_value, feature_position; tlast: last_of_node
//  cfg_    | sink      | tdata: feature_count
//
//  An ordinary element passes through accept, then read-add-write of its sum.
//  A final-neighbour element runs through the 48-step divider before input is taken again.
//  Reset clears every accumulator at once through per-entry valid bits.
//  The result sits in an output register; a stalled sink holds a final
//  element in its last step until that register is free.
// ----------------------------------------------------------------------------
module neighbor_mean_aggregate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [nma_pkg::VAL_W-1:0]            in_tdata,   // [31:0] feature_value
  input  logic                                 in_tlast,   // final_neighbor
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [31:0] mean_value, [38:32] feature_position, [39] zero
  output logic [nma_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,  // last_of_node
  input  logic                                 cfg_tvalid,
  output logic                                 cfg_tready,
  input  logic [nma_pkg::CFG_W-1:0]            cfg_tdata   // [7:0] feature_count
);
  import nma_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CFG_W-1:0]    fcount_r, fcount_nxt;
  logic [POS_W-1:0]    pos_ctr_r, pos_ctr_nxt;
  logic [DEG_W-1:0]    tally_r, tally_nxt;

  logic [VAL_W-1:0]    val_r, val_nxt;
  logic                final_r, final_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                at_end_r, at_end_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_mean_r, out_mean_nxt;
  logic [FPOS_W-1:0]   out_pos_r, out_pos_nxt;
  logic                out_last_r, out_last_nxt;

  logic [CNT_W-1:0]    eff_cnt;
  logic [POS_W-1:0]    pos_eff;
  logic                at_end_cur;
  logic                in_beat;
  logic                out_free;
  logic                finish;

  logic [SUM_W-1:0]    sum_rd;
  logic [SUM_W-1:0]    acc_new;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    total_abs;
  logic [DEG_W-1:0]    degree;

  nma_mem_wr_t         mem_wr;
  nma_div_req_t        div_req;
  nma_div_rsp_t        div_rsp;

  // Effective feature count: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (fcount_r == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (int'(fcount_r) > MAX_FEATURES) begin
      eff_cnt = CNT_W'(MAX_FEATURES);
    end else begin
      eff_cnt = CNT_W'(fcount_r);
    end
  end

  assign pos_eff    = (int'(pos_ctr_r) >= MAX_FEATURES) ? POS_W'(MAX_FEATURES - 1)
                                                        : pos_ctr_r;
  assign at_end_cur = (CNT_W'(pos_eff) + CNT_W'(1)) >= eff_cnt;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;
  assign out_free   = !out_valid_r || out_tready;

  assign acc_new   = sum_rd + SUM_W'(signed'(val_r));
  assign total     = TOT_W'(signed'(sum_rd)) + TOT_W'(signed'(val_r));
  assign total_abs = total[TOT_W-1] ? TOT_W'(-total) : total;
  assign degree    = (int'(tally_r) >= MAX_DEGREE) ? DEG_W'(MAX_DEGREE)
                                                   : DEG_W'(tally_r + 1'b1);

  always_comb begin
    state_nxt     = state_r;
    fcount_nxt    = fcount_r;
    pos_ctr_nxt   = pos_ctr_r;
    tally_nxt     = tally_r;
    val_nxt       = val_r;
    final_nxt     = final_r;
    pos_nxt       = pos_r;
    at_end_nxt    = at_end_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_mean_nxt  = out_mean_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    finish        = 1'b0;

    mem_wr.en       = 1'b0;
    mem_wr.addr     = pos_r;
    mem_wr.data     = '0;
    div_req.start   = 1'b0;
    div_req.neg     = total[TOT_W-1];
    div_req.mag     = total_abs[MAG_W-1:0];
    div_req.divisor = degree;

    if (cfg_tvalid && cfg_tready) begin
      fcount_nxt = cfg_tdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          val_nxt    = in_tdata;
          final_nxt  = in_tlast;
          pos_nxt    = pos_eff;
          at_end_nxt = at_end_cur;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        mem_wr.en = 1'b1;
        if (final_r) begin
          // The final neighbour clears the position for the next node.
          mem_wr.data   = '0;
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          mem_wr.data = acc_new;
          finish      = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = div_rsp.result;
          out_pos_nxt   = FPOS_W'(pos_r);
          out_last_nxt  = at_end_r;
          finish        = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      if (at_end_r) begin
        pos_ctr_nxt = '0;
        if (final_r) begin
          tally_nxt = '0;
        end else if (int'(tally_r) < MAX_DEGREE) begin
          tally_nxt = tally_r + 1'b1;
        end
      end else begin
        pos_ctr_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fcount_r    <= FEATURE_COUNT_RST;
      pos_ctr_r   <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fcount_r    <= fcount_nxt;
      pos_ctr_r   <= pos_ctr_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    final_r    <= final_nxt;
    pos_r      <= pos_nxt;
    at_end_r   <= at_end_nxt;
    out_mean_r <= out_mean_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
  end

  nma_sum_mem u_sum_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (mem_wr),
    .rd_en   (in_beat),
    .rd_addr (pos_eff),
    .rd_data (sum_rd)
  );

  nma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_pos_r, out_mean_r});
  assign out_tlast  = out_last_r;

endmodule

@@ design/nma_checker.sv @@
// ----------------------------------------------------------------------------
// nma_checker: port-level checks for the neighbour mean aggregator
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module nma_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic                                 in_tlast,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [nma_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import nma_pkg::*;

  // A result beat that the sink stalls stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // One element at a time: the block is busy right after taking a beat.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while an element is in progress");

  // An ordinary element is finished after the write-back of its sum.
  a_plain_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tlast |=> ##1 in_tready)
    else $error("ordinary element not finished in two cycles");

  // A final-neighbour element cannot produce its result before the divider.
  a_final_slow: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> ##1 !in_tready)
    else $error("final-neighbour element finished without division");

  // The padding bit above feature_position stays clear.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1] == 1'b0)
    else $error("padding bit set in result beat");

endmodule

bind neighbor_mean_aggregate nma_checker u_nma_checker (.*);

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for neighbor_mean_aggregate
// Streams neighbour feature vectors into the aggregator and compares every
// mean beat with a behavioural predictor. The run has a short directed part
// and random phases under varied idling, stalling and feature counts.
// ----------------------------------------------------------------------------
import nma_pkg::*;

class mean_scoreboard;
  typedef struct {
    logic [VAL_W-1:0]  mean;
    logic [FPOS_W-1:0] pos;
    logic              last;
  } mean_beat_t;

  localparam longint MEAN_HI = 64'sh7FFF_FFFF;
  localparam longint MEAN_LO = -64'sh8000_0000;

  logic [SUM_W-1:0] sums [MAX_FEATURES];
  int unsigned      tally;
  int unsigned      position;
  logic [CFG_W-1:0] feature_count;
  mean_beat_t       means_due [$];

  function new();
    foreach (sums[i]) sums[i] = '0;
    tally         = 0;
    position      = 0;
    feature_count = FEATURE_COUNT_RST;
  endfunction

  function void set_feature_count(logic [CFG_W-1:0] value);
    feature_count = value;
  endfunction

  function int means_pending();
    return means_due.size();
  endfunction

  function void accumulate_element(logic [VAL_W-1:0] value, bit fin);
    int unsigned in_use;
    int unsigned p;
    int unsigned degree;
    bit          at_end;
    longint      total;
    longint      quotient;
    mean_beat_t  beat;
    if (feature_count == 0) begin
      in_use = 1;
    end else if (feature_count > MAX_FEATURES) begin
      in_use = MAX_FEATURES;
    end else begin
      in_use = feature_count;
    end
    p      = (position >= MAX_FEATURES) ? MAX_FEATURES - 1 : position;
    at_end = (p >= in_use - 1);
    if (!fin) begin
      sums[p] = sums[p] + {{(SUM_W - VAL_W){value[VAL_W-1]}}, value};
    end else begin
      degree = (tally + 1 > MAX_DEGREE) ? MAX_DEGREE : tally + 1;
      // The final total is formed at full width; only the stored sums wrap.
      total    = longint'($signed(sums[p])) + longint'($signed(value));
      quotient = total / longint'(degree);
      if (quotient > MEAN_HI) quotient = MEAN_HI;
      if (quotient < MEAN_LO) quotient = MEAN_LO;
      sums[p]   = '0;
      beat.mean = quotient[VAL_W-1:0];
      beat.pos  = p[FPOS_W-1:0];
      beat.last = at_end;
      means_due.push_back(beat);
    end
    if (at_end) begin
      position = 0;
      if (fin) begin
        tally = 0;
      end else if (tally < MAX_DEGREE) begin
        tally++;
      end
    end else begin
      position = p + 1;
    end
  endfunction

  // Returns an empty string when the beat matches the oldest expected mean.
  function string compare_mean(logic [VAL_W-1:0] mean, logic [FPOS_W-1:0] pos,
                               logic last);
    mean_beat_t want;
    if (means_due.size() == 0) begin
      return $sformatf("unexpected mean beat: mean %h pos %0d last %b", mean, pos, last);
    end
    want = means_due.pop_front();
    if (mean !== want.mean || pos !== want.pos || last !== want.last) begin
      return $sformatf("mean beat: got mean %h pos %0d last %b, wanted %h %0d %b",
                       mean, pos, last, want.mean, want.pos, want.last);
    end
    return "";
  endfunction
endclass

module tb;

  localparam int          DRAIN_CYCLES = 64;
  localparam int          HOLD_CYCLES  = 1000;
  localparam int          PHASE_ITEMS  = 90;
  localparam int          REPORT_CAP   = 40;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;

  localparam logic [VAL_W-1:0] FEAT_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] FEAT_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] NEG_ONE  = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0] Q_ONE    = 32'h0001_0000;   // 1.0 in Q16.16

  // Feature count of each random phase, phase 0 in the lowest byte.
  localparam logic [8*CFG_W-1:0] PHASE_COUNTS =
    {8'd2, 8'd128, 8'd11, 8'd1, 8'd6, 8'd255, 8'd0, 8'd3};

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [VAL_W-1:0]       in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_tvalid = 1'b0;
  logic                   cfg_tready;
  logic [CFG_W-1:0]       cfg_tdata  = '0;

  mean_scoreboard sb = new();

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_request   = 0;
  int          vec_len        = MAX_FEATURES;
  int          mismatches     = 0;
  int unsigned cycle_count    = 0;

  neighbor_mean_aggregate u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("neighbor_mean_aggregate: mismatch");
      $finish;
    end
  end

  // Result sink: random stalls, plus a long hold-off whenever one is requested.
  int hold_left  = 0;
  int hold_taken = 0;
  always @(posedge clk) begin
    if (hold_taken != hold_request) begin
      hold_taken = hold_request;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    string why;
    if (rst_n && out_tvalid && out_tready) begin
      why = sb.compare_mean(out_tdata[VAL_W-1:0], out_tdata[VAL_W +: FPOS_W], out_tlast);
      if (why != "") report_mismatch(why);
    end
  end

  task automatic report_mismatch(input string why);
    if (mismatches < REPORT_CAP) $display("%0t: %s", $time, why);
    mismatches++;
  endtask

  task automatic send_element(input logic [VAL_W-1:0] value, input bit fin);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.accumulate_element(value, fin);
  endtask

  // One neighbour vector of random values; mixed gives each beat a random flag.
  task automatic send_vector(input bit fin, input bit mixed);
    logic [VAL_W-1:0] value;
    logic [16:0]      low;
    int unsigned      pick;
    for (int i = 0; i < vec_len; i++) begin
      pick = $urandom_range(99);
      low  = 17'($urandom());
      if (pick < 55) begin
        value = $urandom();
      end else if (pick < 80) begin
        value = {{15{low[16]}}, low};
      end else begin
        case (pick % 5)
          0:       value = FEAT_MAX;
          1:       value = FEAT_MIN;
          2:       value = '0;
          3:       value = NEG_ONE;
          default: value = Q_ONE;
        endcase
      end
      send_element(value, mixed ? bit'($urandom_range(1)) : fin);
    end
  endtask

  task automatic wait_for_means();
    in_tvalid <= 1'b0;
    while (sb.means_pending() != 0) @(posedge clk);
  endtask

  // Non-final beats give no result, so an extra drain covers any still in flight.
  task automatic write_feature_count(input logic [CFG_W-1:0] value);
    wait_for_means();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= value;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    sb.set_feature_count(value);
    if (value == 0) begin
      vec_len = 1;
    end else if (value > MAX_FEATURES) begin
      vec_len = MAX_FEATURES;
    end else begin
      vec_len = value;
    end
  endtask

  initial begin
    int unsigned pick;
    int          deg;
    int          sent;
    bit          paused;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-neighbour node at the value extremes.
    write_feature_count(4);
    send_element(FEAT_MAX, 1'b1);
    send_element(FEAT_MIN, 1'b1);
    send_element(32'h0, 1'b1);
    send_element(NEG_ONE, 1'b1);

    // Two neighbours, largest totals of either sign.
    repeat (2) send_element(FEAT_MAX, 1'b0);
    repeat (2) send_element(FEAT_MIN, 1'b0);
    send_element(FEAT_MAX, 1'b1);
    send_element(FEAT_MIN, 1'b1);
    send_element(FEAT_MAX, 1'b1);
    send_element(FEAT_MIN, 1'b1);

    // Three neighbours: a small negative total must truncate toward zero.
    write_feature_count(2);
    send_element(NEG_ONE, 1'b0);
    send_element(32'd5, 1'b0);
    send_element(NEG_ONE, 1'b0);
    send_element(Q_ONE, 1'b0);
    send_element(32'h0, 1'b1);
    send_element(Q_ONE, 1'b1);

    // Final flags that change within a vector.
    send_element(32'd7, 1'b0);
    send_element(32'd9, 1'b1);
    send_element(32'd2, 1'b1);
    send_element(Q_ONE, 1'b0);

    // Lowering the count in mid-vector ends the vector at the current position.
    write_feature_count(8);
    repeat (3) send_element(Q_ONE, 1'b0);
    write_feature_count(2);
    send_element(NEG_ONE, 1'b1);

    for (int phase = 0; phase < 8; phase++) begin
      write_feature_count(PHASE_COUNTS[CFG_W*phase +: CFG_W]);
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 56;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 56;
        end
        default: begin
          send_idle_pct  = 33;
          recv_stall_pct = 33;
        end
      endcase
      // The sink holds off for a long stretch so that the input backs up.
      if (phase == 0) hold_request++;
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        if (phase == 5 && !paused && sent >= PHASE_ITEMS / 2) begin
          wait_for_means();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 10) begin
          send_vector(1'b0, 1'b1);
          sent += vec_len;
        end else begin
          deg = (pick < 90) ? $urandom_range(1, 4) : $urandom_range(5, 12);
          if (deg * vec_len > PHASE_ITEMS) begin
            deg = (PHASE_ITEMS / vec_len > 0) ? PHASE_ITEMS / vec_len : 1;
          end
          repeat (deg - 1) send_vector(1'b0, 1'b0);
          send_vector(1'b1, 1'b0);
          sent += deg * vec_len;
        end
      end
    end

    wait_for_means();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("neighbor_mean_aggregate: match");
    end else begin
      $display("neighbor_mean_aggregate: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/nma_pkg.sv
design/nma_sum_mem.sv
design/nma_div.sv
design/neighbor_mean_aggregate.sv
design/nma_checker.sv
test/tb.sv
